@@ sv/tdp_pkg.sv @@
// package for the trial division prime test block
// holds the datapath width, the candidate word type and the sequencer states
// no dependencies
package tdp_pkg;

   // width of the candidate datapath (8 to 64)
   localparam int NUM_WIDTH = 32;
   // width of the candidate port
   localparam int CAND_WIDTH = 32;
   // bit counter of the shared divider
   localparam int CNT_W = (NUM_WIDTH > 1) ? $clog2(NUM_WIDTH) : 1;

   typedef logic [NUM_WIDTH-1:0] num_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_CHECK
   } state_type;

endpackage

@@ sv/trial_division_prime_test_top.sv @@
// trial division primality test, one candidate per item, one verdict per item
// uses tdp_pkg for the datapath width, word types and sequencer states
// 0..3 and even candidates are answered in the cycle after acceptance; otherwise the
// candidate is divided by each odd trial divisor 3, 5, 7, ... up to sqrt(n) in turn on the
// shared one bit per cycle restoring divider, with a check state after each full pass
// throughput: one item at a time, busy stays high until the verdict is issued
// the verdict strobe lasts one cycle and cannot be held off by the receiver
// reset (synchronous, active high) returns the sequencer to idle and drops the strobe
module trial_division_prime_test_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [tdp_pkg::CAND_WIDTH-1:0] req_candidate,
   output logic                           rsp_valid,
   output logic                           rsp_is_prime
);

   tdp_pkg::state_type state_ff, state_in;
   tdp_pkg::num_type   n_ff, n_in;
   tdp_pkg::num_type   d_ff, d_in;
   tdp_pkg::num_type   rem_ff, rem_in;
   tdp_pkg::num_type   quo_ff, quo_in;
   tdp_pkg::cnt_type   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_is_prime_ff, rsp_is_prime_in;

   tdp_pkg::num_type          cand;
   logic [tdp_pkg::NUM_WIDTH:0] trial;
   logic [tdp_pkg::NUM_WIDTH:0] diff;
   logic                      accept;

   assign cand   = tdp_pkg::num_type'(req_candidate);
   assign busy   = (state_ff != tdp_pkg::ST_IDLE);
   assign accept = start && !busy;

   // shared divider step: shift in next dividend bit, try to subtract divisor
   assign trial = {rem_ff, quo_ff[tdp_pkg::NUM_WIDTH-1]};
   assign diff  = trial - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      d_ff            <= d_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   always_comb begin
      state_in        = state_ff;
      n_in            = n_ff;
      d_in            = d_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = 1'b0;
      rsp_is_prime_in = rsp_is_prime_ff;

      unique case (state_ff)
         tdp_pkg::ST_IDLE: begin
            if (start) begin
               n_in   = cand;
               d_in   = tdp_pkg::num_type'(3);
               rem_in = '0;
               quo_in = cand;
               cnt_in = '0;
               if (cand <= tdp_pkg::num_type'(1)) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
               end else if (cand <= tdp_pkg::num_type'(3)) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b1;
               end else if (!cand[0]) begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_prime_in = 1'b0;
               end else begin
                  state_in = tdp_pkg::ST_DIVIDE;
               end
            end
         end
         tdp_pkg::ST_DIVIDE: begin
            if (!diff[tdp_pkg::NUM_WIDTH]) begin
               rem_in = diff[tdp_pkg::NUM_WIDTH-1:0];
               quo_in = {quo_ff[tdp_pkg::NUM_WIDTH-2:0], 1'b1};
            end else begin
               rem_in = trial[tdp_pkg::NUM_WIDTH-1:0];
               quo_in = {quo_ff[tdp_pkg::NUM_WIDTH-2:0], 1'b0};
            end
            cnt_in = cnt_ff + tdp_pkg::cnt_type'(1);
            if (cnt_ff == tdp_pkg::cnt_type'(tdp_pkg::NUM_WIDTH - 1)) begin
               state_in = tdp_pkg::ST_CHECK;
            end
         end
         tdp_pkg::ST_CHECK: begin
            // divisor past the square root bound: no factor found
            if (d_ff > quo_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = 1'b1;
               state_in        = tdp_pkg::ST_IDLE;
            end else if (rem_ff == '0) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = 1'b0;
               state_in        = tdp_pkg::ST_IDLE;
            end else begin
               d_in     = d_ff + tdp_pkg::num_type'(2);
               rem_in   = '0;
               quo_in   = n_ff;
               cnt_in   = '0;
               state_in = tdp_pkg::ST_DIVIDE;
            end
         end
         default: begin
            state_in = tdp_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // a verdict only follows a finished check or an item settled on acceptance
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == tdp_pkg::ST_CHECK || (start && !busy)))
      else $error("verdict without a finished check or an accepted item");

   // an accepted item either answers at once or starts dividing
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || state_ff == tdp_pkg::ST_DIVIDE))
      else $error("accepted item neither answered nor started");

   // trial divisor stays odd and at least three while a test runs
   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      busy |-> (d_ff[0] && d_ff >= tdp_pkg::num_type'(3)))
      else $error("trial divisor left the odd sequence");

   // the check state is entered only after a full pass of the divider
   a_check_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdp_pkg::ST_CHECK) |->
         $past(state_ff == tdp_pkg::ST_DIVIDE &&
               cnt_ff == tdp_pkg::cnt_type'(tdp_pkg::NUM_WIDTH - 1)))
      else $error("check entered before the division finished");

   // the divider remainder is always below the divisor once a pass ends
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdp_pkg::ST_CHECK) |-> (rem_ff < d_ff))
      else $error("remainder not below divisor");

endmodule
